// ----- rtl/core/assert_macros.svh -----
// Assertion helpers for the RTL; included by aalu_ctrl.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Property checked every clock, off during reset.
`define AALU_ASSERT(lbl, clk, rstn, prop) \
	lbl: assert property (@(posedge clk) disable iff (!rstn) (prop)) \
		else $error("aalu assertion failed");

// Antecedent now, consequent on the next clock.
`define AALU_ASSERT_NEXT(lbl, clk, rstn, ante, cons) \
	lbl: assert property (@(posedge clk) disable iff (!rstn) (ante) |=> (cons)) \
		else $error("aalu assertion failed");

`endif

// ----- rtl/core/aalu_pkg.sv -----
`default_nettype none
package aalu_pkg;
	localparam int unsigned DataW = 64;
	localparam int unsigned HalfW = DataW / 2;
	localparam int unsigned OpW   = 5;
	localparam int unsigned CntW  = $clog2(DataW);

	typedef enum logic [OpW-1:0] {
		OP_ASSIGN = 5'd0,  OP_ADD = 5'd1,  OP_SUB = 5'd2,  OP_MUL = 5'd3,
		OP_DIV    = 5'd4,  OP_MOD = 5'd5,  OP_SHL = 5'd6,  OP_SHR = 5'd7,
		OP_EQ     = 5'd8,  OP_NE  = 5'd9,  OP_LE  = 5'd10, OP_LT  = 5'd11,
		OP_GE     = 5'd12, OP_GT  = 5'd13, OP_AND = 5'd14, OP_OR  = 5'd15,
		OP_XOR    = 5'd16, OP_LAND = 5'd17, OP_LOR = 5'd18, OP_LXOR = 5'd19,
		OP_NEG    = 5'd20, OP_LNOT = 5'd21, OP_BNOT = 5'd22
	} op_t;

	// controller -> datapath
	typedef struct packed {
		logic       load;      // capture input beat
		logic       mul_step;
		logic [1:0] mul_idx;
		logic       div_step;
		logic       commit;    // write accumulator and result register
	} cmd_t;

	// datapath -> controller, decoded from the input beat
	typedef struct packed {
		logic is_mul;
		logic is_div;          // div/mod with nonzero divisor
	} sts_t;
endpackage
`default_nettype wire

// ----- rtl/core/accumulator_alu_u64.sv -----
`default_nettype none
// 64-bit unsigned accumulator ALU. Each input beat carries an opcode (s_tuser) and an
// operand (s_tdata); each produces exactly one output beat with the new accumulator
// value and, for compares and logical tests, a flag. Items are handled one at a time:
// simple ops go from the input register straight to the commit state, multiply runs four
// steps on one shared 32x32 multiplier, divide and modulo run the restoring divider at
// one quotient bit per cycle. A result waiting in the output register blocks the next
// input beat until that result is taken. Accumulator resets to zero. Shifts by 64 or
// more and division by zero give 0; unknown opcodes leave the accumulator as it is.
module accumulator_alu_u64 #(
	parameter int unsigned DATA_W = aalu_pkg::DataW
) (
	input  wire logic              clk,
	input  wire logic              arst_n,
	input  wire logic              s_tvalid,
	output logic                   s_tready,
	input  wire logic [DATA_W-1:0] s_tdata,   // [63:0] operand
	input  wire logic [7:0]        s_tuser,   // [4:0] op, rest zero
	output logic                   m_tvalid,
	input  wire logic              m_tready,
	output logic [DATA_W-1:0]      m_tdata,   // [63:0] acc_value
	output logic [7:0]             m_tuser    // [0] flag, [1] flag_valid, rest zero
);
	import aalu_pkg::*;

	cmd_t cmd;
	sts_t sts;
	logic flag, flag_valid;

	aalu_ctrl #(.DATA_W(DATA_W)) u_ctrl (
		.clk, .arst_n,
		.in_valid(s_tvalid), .in_ready(s_tready),
		.out_valid(m_tvalid), .out_ready(m_tready),
		.sts, .cmd
	);

	aalu_dp #(.DATA_W(DATA_W)) u_dp (
		.clk, .arst_n, .cmd, .sts,
		.in_operand(s_tdata), .in_op(s_tuser[OpW-1:0]),
		.res_acc(m_tdata), .res_flag(flag), .res_flag_valid(flag_valid)
	);

	assign m_tuser = {6'd0, flag_valid, flag};
endmodule
`default_nettype wire

// ----- rtl/core/aalu_dp.sv -----
`default_nettype none
module aalu_dp #(
	parameter int unsigned DATA_W = aalu_pkg::DataW
) (
	input  wire logic                  clk,
	input  wire logic                  arst_n,
	input  wire aalu_pkg::cmd_t        cmd,
	output aalu_pkg::sts_t             sts,
	input  wire logic [DATA_W-1:0]     in_operand,
	input  wire logic [aalu_pkg::OpW-1:0] in_op,
	output logic [DATA_W-1:0]          res_acc,
	output logic                       res_flag,
	output logic                       res_flag_valid
);
	import aalu_pkg::*;

	localparam int unsigned HW = DATA_W / 2;
	localparam int unsigned SW = $clog2(DATA_W);

	logic [DATA_W-1:0] acc_q, b_q, quo_q, rem_q, mres_q, prod_q;
	op_t               op_q;
	logic [HW-1:0]     mx, my;
	logic [DATA_W:0]   trial;
	logic [DATA_W-1:0] nxt;
	logic              f, t, az, bz;

	assign sts.is_mul = (op_t'(in_op) == OP_MUL);
	assign sts.is_div = ((op_t'(in_op) == OP_DIV) || (op_t'(in_op) == OP_MOD))
		&& (in_operand != '0);

	// shared multiplier, one partial product per step
	always_comb begin
		mx = (cmd.mul_idx == 2'd2) ? acc_q[DATA_W-1:HW] : acc_q[HW-1:0];
		my = (cmd.mul_idx == 2'd1) ? b_q[DATA_W-1:HW] : b_q[HW-1:0];
	end

	assign trial = {rem_q, quo_q[DATA_W-1]} - {1'b0, b_q};

	always_comb begin
		az  = (acc_q == '0);
		bz  = (b_q == '0);
		nxt = acc_q;
		f   = 1'b0;
		t   = 1'b0;
		case (op_q)
			OP_ASSIGN: nxt = b_q;
			OP_ADD:    nxt = acc_q + b_q;
			OP_SUB:    nxt = acc_q - b_q;
			OP_MUL:    nxt = mres_q;
			OP_DIV:    nxt = bz ? '0 : quo_q;
			OP_MOD:    nxt = bz ? '0 : rem_q;
			OP_SHL:    nxt = (b_q[DATA_W-1:SW] == '0) ? (acc_q << b_q[SW-1:0]) : '0;
			OP_SHR:    nxt = (b_q[DATA_W-1:SW] == '0) ? (acc_q >> b_q[SW-1:0]) : '0;
			OP_EQ:     begin t = 1'b1; f = (acc_q == b_q); end
			OP_NE:     begin t = 1'b1; f = (acc_q != b_q); end
			OP_LE:     begin t = 1'b1; f = (acc_q <= b_q); end
			OP_LT:     begin t = 1'b1; f = (acc_q <  b_q); end
			OP_GE:     begin t = 1'b1; f = (acc_q >= b_q); end
			OP_GT:     begin t = 1'b1; f = (acc_q >  b_q); end
			OP_AND:    nxt = acc_q & b_q;
			OP_OR:     nxt = acc_q | b_q;
			OP_XOR:    nxt = acc_q ^ b_q;
			OP_LAND:   begin t = 1'b1; f = !az && !bz; end
			OP_LOR:    begin t = 1'b1; f = !az || !bz; end
			OP_LXOR:   begin t = 1'b1; f = az != bz; end
			OP_NEG:    nxt = '0 - acc_q;
			OP_LNOT:   nxt = az ? DATA_W'(1) : '0;
			OP_BNOT:   nxt = ~acc_q;
			default:   nxt = acc_q;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			acc_q <= '0;
		end else if (cmd.commit) begin
			acc_q <= nxt;
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.load) begin
			op_q  <= op_t'(in_op);
			b_q   <= in_operand;
			quo_q <= acc_q;
			rem_q <= '0;
		end
		if (cmd.div_step) begin
			if (!trial[DATA_W]) begin
				rem_q <= trial[DATA_W-1:0];
				quo_q <= {quo_q[DATA_W-2:0], 1'b1};
			end else begin
				rem_q <= {rem_q[DATA_W-2:0], quo_q[DATA_W-1]};
				quo_q <= {quo_q[DATA_W-2:0], 1'b0};
			end
		end
		if (cmd.mul_step) begin
			prod_q <= mx * my;
			case (cmd.mul_idx)
				2'd0:    mres_q <= mres_q;
				2'd1:    mres_q <= prod_q;
				default: mres_q <= mres_q + {prod_q[HW-1:0], {HW{1'b0}}};
			endcase
		end
		if (cmd.commit) begin
			res_acc        <= nxt;
			res_flag       <= f;
			res_flag_valid <= t;
		end
	end
endmodule
`default_nettype wire

// ----- rtl/core/aalu_ctrl.sv -----
`default_nettype none
`include "assert_macros.svh"
module aalu_ctrl #(
	parameter int unsigned DATA_W = aalu_pkg::DataW
) (
	input  wire logic           clk,
	input  wire logic           arst_n,
	input  wire logic           in_valid,
	output logic                in_ready,
	output logic                out_valid,
	input  wire logic           out_ready,
	input  wire aalu_pkg::sts_t sts,
	output aalu_pkg::cmd_t      cmd
);
	import aalu_pkg::*;

	localparam int unsigned CW = $clog2(DATA_W);

	typedef enum logic [1:0] {ST_IDLE, ST_MUL, ST_DIV, ST_EXEC} state_t;

	state_t        state_q;
	logic [CW-1:0] cnt_q;
	logic          out_valid_q;
	logic          take;

	assign in_ready  = (state_q == ST_IDLE) && (!out_valid_q || out_ready);
	assign take      = in_valid && in_ready;
	assign out_valid = out_valid_q;

	always_comb begin
		cmd          = '0;
		cmd.load     = take;
		cmd.mul_step = (state_q == ST_MUL);
		cmd.mul_idx  = cnt_q[1:0];
		cmd.div_step = (state_q == ST_DIV);
		cmd.commit   = (state_q == ST_EXEC);
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= ST_IDLE;
			cnt_q       <= '0;
			out_valid_q <= 1'b0;
		end else begin
			if (out_valid_q && out_ready) out_valid_q <= 1'b0;
			case (state_q)
				ST_IDLE: begin
					cnt_q <= '0;
					if (take) begin
						if (sts.is_mul)      state_q <= ST_MUL;
						else if (sts.is_div) state_q <= ST_DIV;
						else                 state_q <= ST_EXEC;
					end
				end
				ST_MUL: begin
					cnt_q <= cnt_q + 1'b1;
					if (cnt_q[1:0] == 2'd3) state_q <= ST_EXEC;
				end
				ST_DIV: begin
					cnt_q <= cnt_q + 1'b1;
					if (cnt_q == '1) state_q <= ST_EXEC;
				end
				ST_EXEC: begin
					out_valid_q <= 1'b1;
					state_q     <= ST_IDLE;
				end
				default: state_q <= ST_IDLE;
			endcase
		end
	end

	`AALU_ASSERT(a_no_overwrite, clk, arst_n, !cmd.commit || !out_valid_q)
	`AALU_ASSERT_NEXT(a_one_item, clk, arst_n, take, !in_ready)
	`AALU_ASSERT_NEXT(a_div_len, clk, arst_n, (state_q == ST_DIV) && (cnt_q == '1),
		state_q == ST_EXEC)
endmodule
`default_nettype wire

// ----- tb/accumulator_alu_u64_checker.sv -----
`default_nettype none
module accumulator_alu_u64_checker (
	input  wire logic        clk,
	input  wire logic        arst_n,
	input  wire logic        s_tvalid,
	input  wire logic        s_tready,
	input  wire logic [63:0] s_tdata,
	input  wire logic [7:0]  s_tuser,
	input  wire logic        m_tvalid,
	input  wire logic        m_tready,
	input  wire logic [63:0] m_tdata,
	input  wire logic [7:0]  m_tuser,
	output int               fail_count,
	output int               pending
);
	timeunit 1ns;
	timeprecision 1ps;
	import aalu_pkg::*;

	typedef struct packed {
		logic [63:0] acc_value;
		logic        flag;
		logic        flag_valid;
	} alu_result_t;

	logic [63:0] acc_model;
	alu_result_t result_q[$];

	function automatic alu_result_t apply_op(input logic [4:0] opc, input logic [63:0] b);
		alu_result_t r;
		logic [63:0] a;
		a = acc_model;
		r.flag = 1'b0;
		r.flag_valid = 1'b0;
		case (opc)
			OP_ASSIGN: a = b;
			OP_ADD:    a = a + b;
			OP_SUB:    a = a - b;
			OP_MUL:    a = a * b;
			OP_DIV:    a = (b != 0) ? a / b : 64'd0;
			OP_MOD:    a = (b != 0) ? a % b : 64'd0;
			OP_SHL:    a = (b < 64) ? a << b[5:0] : 64'd0;
			OP_SHR:    a = (b < 64) ? a >> b[5:0] : 64'd0;
			OP_EQ:     begin r.flag_valid = 1; r.flag = (a == b); end
			OP_NE:     begin r.flag_valid = 1; r.flag = (a != b); end
			OP_LE:     begin r.flag_valid = 1; r.flag = (a <= b); end
			OP_LT:     begin r.flag_valid = 1; r.flag = (a < b); end
			OP_GE:     begin r.flag_valid = 1; r.flag = (a >= b); end
			OP_GT:     begin r.flag_valid = 1; r.flag = (a > b); end
			OP_AND:    a = a & b;
			OP_OR:     a = a | b;
			OP_XOR:    a = a ^ b;
			OP_LAND:   begin r.flag_valid = 1; r.flag = (a != 0) && (b != 0); end
			OP_LOR:    begin r.flag_valid = 1; r.flag = (a != 0) || (b != 0); end
			OP_LXOR:   begin r.flag_valid = 1; r.flag = (a != 0) != (b != 0); end
			OP_NEG:    a = 64'd0 - a;
			OP_LNOT:   a = (a == 0) ? 64'd1 : 64'd0;
			OP_BNOT:   a = ~a;
			default:   ;
		endcase
		acc_model = a;
		r.acc_value = a;
		return r;
	endfunction

	always @(posedge clk or negedge arst_n) begin
		alu_result_t got, want;
		if (!arst_n) begin
			acc_model = '0;
			fail_count = 0;
			pending = 0;
			result_q.delete();
		end else begin
			if (s_tvalid && s_tready)
				result_q.push_back(apply_op(s_tuser[4:0], s_tdata));
			if (m_tvalid && m_tready) begin
				got = {m_tdata, m_tuser[0], m_tuser[1]};
				if (result_q.size() == 0) begin
					if (fail_count < 10)
						$display("%t: result beat with nothing expected: %h", $realtime, got);
					fail_count++;
				end else begin
					want = result_q.pop_front();
					if (got !== want || m_tuser[7:2] !== 6'd0) begin
						if (fail_count < 10)
							$display("%t: mismatch acc exp %h got %h, flag exp %b got %b, fv exp %b got %b",
								$realtime, want.acc_value, got.acc_value, want.flag, got.flag,
								want.flag_valid, got.flag_valid);
						fail_count++;
					end
				end
			end
			pending = result_q.size();
		end
	end
endmodule
`default_nettype wire

// ----- tb/accumulator_alu_u64_test.sv -----
`default_nettype none
module accumulator_alu_u64_test;
	timeunit 1ns;
	timeprecision 1ps;
	import aalu_pkg::*;

	logic        clk = 0;
	logic        arst_n = 0;
	logic        s_tvalid = 0;
	logic        s_tready;
	logic [63:0] s_tdata = '0;
	logic [7:0]  s_tuser = '0;   // [4:0] op
	logic        m_tvalid;
	logic        m_tready = 0;
	logic [63:0] m_tdata;        // [63:0] acc_value
	logic [7:0]  m_tuser;        // [0] flag, [1] flag_valid
	int          fail_count;
	int          pending;

	// idle percentages per phase, picked up by both sides
	int send_idle = 0;
	int recv_idle = 0;
	bit hold_off = 0;            // long receiver stall in progress

	always #5 clk = ~clk;

	accumulator_alu_u64 i_dut (
		.clk, .arst_n, .s_tvalid, .s_tready, .s_tdata, .s_tuser,
		.m_tvalid, .m_tready, .m_tdata, .m_tuser
	);

	accumulator_alu_u64_checker i_chk (
		.clk, .arst_n, .s_tvalid, .s_tready, .s_tdata, .s_tuser,
		.m_tvalid, .m_tready, .m_tdata, .m_tuser, .fail_count, .pending
	);

	// receiver: random stalls, plus a forced long stall when hold_off is set
	always @(posedge clk) begin
		if (!arst_n)
			m_tready <= 1'b0;
		else
			m_tready <= !hold_off && ($urandom_range(99) >= recv_idle);
	end

	// random operand biased toward corner values and small numbers
	function automatic logic [63:0] pick_operand();
		case ($urandom_range(7))
			0: return 64'd0;
			1: return '1;
			2: return 64'(($urandom_range(70)));
			3: return 64'h8000_0000_0000_0000 >> $urandom_range(63);
			4: return {32'd0, 32'($urandom)};
			default: return {32'($urandom), 32'($urandom)};
		endcase
	endfunction

	// offer one beat, with random gaps before it, and wait for acceptance;
	// tvalid stays up after the beat so back-to-back beats need no gap
	task automatic send_beat(input logic [4:0] opc, input logic [63:0] val);
		while ($urandom_range(99) < send_idle) begin
			s_tvalid <= 1'b0;
			@(posedge clk);
		end
		s_tvalid <= 1'b1;
		s_tdata  <= val;
		s_tuser  <= {3'b000, opc};
		@(posedge clk);
		while (!s_tready)
			@(posedge clk);
	endtask

	// drop tvalid and wait until every expected result is back
	task automatic drain();
		s_tvalid <= 1'b0;
		@(posedge clk);
		while (pending != 0)
			@(posedge clk);
	endtask

	task automatic random_burst(input int count);
		logic [4:0] opc;
		repeat (count) begin
			// mostly legal opcodes, some unknown ones; div/mod rarer since they are slow
			opc = ($urandom_range(19) == 0) ? 5'($urandom_range(31, 23))
				: 5'($urandom_range(22));
			if ((opc == OP_DIV || opc == OP_MOD) && $urandom_range(2) != 0)
				opc = OP_ASSIGN;
			send_beat(opc, pick_operand());
		end
	endtask

	initial begin
		#5ms;
		$display("Regression FAIL");
		$finish;
	end

	initial begin
		repeat (2) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// directed: corner operands, all opcodes but AND, OR, XOR, LAND and LOR, special cases
		send_beat(OP_ASSIGN, '1);
		send_beat(OP_ADD, 64'd1);                 // wraps to zero
		send_beat(OP_LNOT, 64'd0);                // zero -> one
		send_beat(OP_LNOT, '1);                   // one -> zero
		send_beat(OP_SUB, 64'd1);                 // underflow wrap
		send_beat(OP_MUL, 64'hFFFF_FFFF_0000_0001);
		send_beat(OP_DIV, 64'd0);                 // divide by zero
		send_beat(OP_ASSIGN, 64'h1234_5678_9ABC_DEF0);
		send_beat(OP_MOD, 64'd0);                 // modulo by zero
		send_beat(OP_ASSIGN, '1);
		send_beat(OP_DIV, 64'd3);
		send_beat(OP_MOD, 64'hFFFF_FFFF);
		send_beat(OP_ASSIGN, 64'hDEAD_BEEF_0000_0001);
		send_beat(OP_SHL, 64'd63);
		send_beat(OP_SHR, 64'd64);                // long shift
		send_beat(OP_EQ, 64'd0);
		send_beat(OP_NE, '1);
		send_beat(OP_LE, 64'd0);
		send_beat(OP_LT, '1);
		send_beat(OP_GE, 64'd0);
		send_beat(OP_GT, '1);
		send_beat(OP_LXOR, 64'd5);                // zero acc, nonzero operand
		send_beat(OP_NEG, '1);
		send_beat(OP_BNOT, 64'd0);
		send_beat(5'd31, '1);                     // unknown opcode
		drain();

		random_burst(200);
		send_idle = 85;
		random_burst(200);
		send_idle = 0;  recv_idle = 85;
		random_burst(200);
		send_idle = 28; recv_idle = 28;
		random_burst(200);

		// long receiver stall while the sender keeps offering beats
		send_idle = 0;  recv_idle = 0;
		hold_off = 1'b1;
		fork
			begin
				repeat (300) @(posedge clk);
				hold_off = 1'b0;
			end
			random_burst(50);
		join
		// sender pauses until all results are back, then continues
		drain();
		random_burst(150);

		drain();
		repeat (100) @(posedge clk);
		if (fail_count == 0 && pending == 0)
			$display("Regression PASS");
		else
			$display("Regression FAIL");
		$finish;
	end
endmodule
`default_nettype wire

// ----- files.f -----
+incdir+rtl/core
rtl/core/aalu_pkg.sv
rtl/core/aalu_dp.sv
rtl/core/aalu_ctrl.sv
rtl/core/accumulator_alu_u64.sv
tb/accumulator_alu_u64_checker.sv
tb/accumulator_alu_u64_test.sv
